// ----- src/frame_redirect_classify_rewrite_top_macros.svh -----
// Assertion macros shared by the frame redirect block.
`ifndef FRAME_REDIRECT_CLASSIFY_REWRITE_TOP_MACROS_SVH
`define FRAME_REDIRECT_CLASSIFY_REWRITE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FRCR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FRCR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/frcr_pkg.sv -----
// Types and constants of the frame redirect classifier.
package frcr_pkg;

	// Frame layout
	localparam int MAC_BYTES    = 6;
	localparam int ETYPE_HI_POS = 12;
	localparam int ETYPE_LO_POS = 13;
	localparam int IP4_ADDR_POS = 14 + 16;
	localparam int IP6_ADDR_POS = 14 + 24;
	localparam int ADDR4_LEN    = 4;
	localparam int ADDR6_LEN    = 16;
	localparam int IP4_ADDR_END = IP4_ADDR_POS + ADDR4_LEN;
	localparam int IP6_ADDR_END = IP6_ADDR_POS + ADDR6_LEN;

	localparam logic [15:0] ETYPE_IP4 = 16'h0800;
	localparam logic [15:0] ETYPE_IP6 = 16'h86DD;

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPOOF_MAC   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HIGH  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_LOW   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_SIZE   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY     = 4'd7;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       redirect;
	} out_t;

	typedef struct packed {
		logic [47:0] local_mac;
		logic [47:0] spoof_mac;
		logic [63:0] local_addr_high;
		logic [63:0] local_addr_low;
		logic [63:0] target_addr_high;
		logic [63:0] target_addr_low;
		logic [4:0]  addr_size;
		logic        gateway_mode;
	} cfg_t;

endpackage

// ----- src/frcr_cfg_regs.sv -----
// Configuration register file of the frame redirect classifier.
module frcr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [frcr_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [63:0]                    wr_data,
	output frcr_pkg::cfg_t                 cfg
);

	frcr_pkg::cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_mac        <= '0;
			cfg_q.spoof_mac        <= '0;
			cfg_q.local_addr_high  <= '0;
			cfg_q.local_addr_low   <= '0;
			cfg_q.target_addr_high <= '0;
			cfg_q.target_addr_low  <= '0;
			cfg_q.addr_size        <= 5'd4;
			cfg_q.gateway_mode     <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				frcr_pkg::REG_LOCAL_MAC:   cfg_q.local_mac        <= wr_data[47:0];
				frcr_pkg::REG_SPOOF_MAC:   cfg_q.spoof_mac        <= wr_data[47:0];
				frcr_pkg::REG_LOCAL_HIGH:  cfg_q.local_addr_high  <= wr_data;
				frcr_pkg::REG_LOCAL_LOW:   cfg_q.local_addr_low   <= wr_data;
				frcr_pkg::REG_TARGET_HIGH: cfg_q.target_addr_high <= wr_data;
				frcr_pkg::REG_TARGET_LOW:  cfg_q.target_addr_low  <= wr_data;
				frcr_pkg::REG_ADDR_SIZE:   cfg_q.addr_size        <= wr_data[4:0];
				frcr_pkg::REG_GATEWAY:     cfg_q.gateway_mode     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- src/frcr_engine.sv -----
// Per-byte classifier: frame position, match flags, MAC rewrite and verdict.
module frcr_engine #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  frcr_pkg::cfg_t cfg,
	input  frcr_pkg::in_t  item,
	input  logic           commit,
	output frcr_pkg::out_t result
);

	localparam int PW = $clog2(MAX_FRAME_BYTES);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_FRAME_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic          mac_eq_q;
	logic [15:0]   ekind_q;
	logic          local_eq_q;
	logic          target_eq_q;

	logic [PW-1:0] pos_d;
	logic          mac_eq_d;
	logic [15:0]   ekind_d;
	logic          local_eq_d;
	logic          target_eq_d;

	logic          in_mac;
	logic [7:0]    lmac_byte;
	logic [7:0]    smac_byte;
	logic          is4;
	logic          is6;
	logic [PW-1:0] start_w;
	logic [PW-1:0] end_w;
	logic [4:0]    len_w;
	logic          in_win;
	logic [3:0]    aidx;
	logic [7:0]    laddr_byte;
	logic [7:0]    taddr_byte;
	logic          complete;
	logic          verdict;

	// MAC byte i of a 48-bit MAC, byte 0 most significant
	function automatic logic [7:0] mac_byte(input logic [47:0] m, input logic [2:0] i);
		logic [7:0] r;
		begin
			case (i)
				3'd0:    r = m[47:40];
				3'd1:    r = m[39:32];
				3'd2:    r = m[31:24];
				3'd3:    r = m[23:16];
				3'd4:    r = m[15:8];
				3'd5:    r = m[7:0];
				default: r = 8'h00;
			endcase
			return r;
		end
	endfunction

	// Address byte i, first byte most significant; short form uses lo[31:0]
	function automatic logic [7:0] addr_byte(input logic [63:0] hi, input logic [63:0] lo,
			input logic [3:0] i, input logic short_form);
		logic [63:0] sh;
		begin
			if (short_form)
				sh = lo >> {3'b000, ~i[1:0], 3'b000};
			else if (!i[3])
				sh = hi >> {~i[2:0], 3'b000};
			else
				sh = lo >> {~i[2:0], 3'b000};
			return sh[7:0];
		end
	endfunction

	// Destination MAC compare and rewrite
	assign in_mac    = pos_q < PW'(frcr_pkg::MAC_BYTES);
	assign lmac_byte = mac_byte(cfg.local_mac, pos_q[2:0]);
	assign smac_byte = mac_byte(cfg.spoof_mac, pos_q[2:0]);
	assign mac_eq_d  = mac_eq_q & ~(in_mac & (lmac_byte != item.frame_byte));

	// EtherType capture
	always_comb begin
		ekind_d = ekind_q;
		if (pos_q == PW'(frcr_pkg::ETYPE_HI_POS))
			ekind_d[15:8] = item.frame_byte;
		else if (pos_q == PW'(frcr_pkg::ETYPE_LO_POS))
			ekind_d[7:0] = item.frame_byte;
	end

	// Address window of the network header
	assign is4 = ekind_d == frcr_pkg::ETYPE_IP4;
	assign is6 = ekind_d == frcr_pkg::ETYPE_IP6;

	always_comb begin
		start_w = PW'(frcr_pkg::IP6_ADDR_POS);
		end_w   = PW'(frcr_pkg::IP6_ADDR_END);
		len_w   = 5'(frcr_pkg::ADDR6_LEN);
		if (is4) begin
			start_w = PW'(frcr_pkg::IP4_ADDR_POS);
			end_w   = PW'(frcr_pkg::IP4_ADDR_END);
			len_w   = 5'(frcr_pkg::ADDR4_LEN);
		end
	end

	assign in_win     = (is4 | is6) & (pos_q >= start_w) & (pos_q < end_w);
	assign aidx       = 4'(pos_q - start_w);
	assign laddr_byte = addr_byte(cfg.local_addr_high, cfg.local_addr_low, aidx, is4);
	assign taddr_byte = addr_byte(cfg.target_addr_high, cfg.target_addr_low, aidx, is4);
	assign local_eq_d  = local_eq_q & ~(in_win & (laddr_byte != item.frame_byte));
	assign target_eq_d = target_eq_q & ~(in_win & (taddr_byte != item.frame_byte));

	// Verdict on the final byte
	assign complete = (is4 | is6) & (pos_q >= end_w - PW'(1));
	assign verdict  = mac_eq_d & complete & (cfg.addr_size == len_w) &
		(cfg.gateway_mode ? ~local_eq_d : target_eq_d);

	assign result.out_byte  = in_mac ? smac_byte : item.frame_byte;
	assign result.frame_end = item.last_byte;
	assign result.redirect  = item.last_byte & verdict;

	// Saturating frame position
	assign pos_d = (pos_q < POS_MAX) ? pos_q + PW'(1) : pos_q;

	// Frame state, restarted after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			mac_eq_q    <= 1'b1;
			ekind_q     <= '0;
			local_eq_q  <= 1'b1;
			target_eq_q <= 1'b1;
		end else if (commit) begin
			if (item.last_byte) begin
				pos_q       <= '0;
				mac_eq_q    <= 1'b1;
				ekind_q     <= '0;
				local_eq_q  <= 1'b1;
				target_eq_q <= 1'b1;
			end else begin
				pos_q       <= pos_d;
				mac_eq_q    <= mac_eq_d;
				ekind_q     <= ekind_d;
				local_eq_q  <= local_eq_d;
				target_eq_q <= target_eq_d;
			end
		end
	end

endmodule

// ----- src/frame_redirect_classify_rewrite_top.sv -----
// A byte taken in is held in the input register until the result register is free, then its
// classified result moves into the result register and is offered at the output.
// Throughput: one byte per cycle; the input register is refilled in the cycle its byte
// moves into the output register, so the only wait is a stall from the output side.
// The classifier state (position, match flags, EtherType) updates once per byte.
// Reset (arst_n low, asynchronous) empties both registers, restarts the frame state
// and loads the registers with their defaults (addr_size 4, everything else zero).
`include "frame_redirect_classify_rewrite_top_macros.svh"

module frame_redirect_classify_rewrite_top #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  frcr_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output frcr_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [frcr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);

	frcr_pkg::cfg_t cfg;
	frcr_pkg::in_t  data_s1;
	logic           valid_s1;
	frcr_pkg::out_t result;
	frcr_pkg::out_t data_s2;
	logic           valid_s2;
	logic           adv;

	assign cfg_ready = 1'b1;

	frcr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Byte in the input register moves on when the output register is free
	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	frcr_engine #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (data_s1),
		.commit (adv),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// Checks
	`FRCR_ASSERT_IMP(a_redirect_at_end, out_valid && out_data.redirect, out_data.frame_end, "redirect without frame end")
	`FRCR_ASSERT_NXT(a_s1_held, valid_s1 && !adv, valid_s1 && $stable(data_s1), "input register lost a byte")
	`FRCR_ASSERT_NXT(a_adv_fills_out, adv, valid_s2, "advanced byte missing at output")

endmodule

// ----- tb/frame_redirect_classify_rewrite_top_test.sv -----
// Self-checking testbench for the frame redirect classifier and destination MAC rewriter.
`timescale 1ns / 1ps

module frame_redirect_classify_rewrite_top_test;

	localparam int FRAME_CAP    = 2048;
	localparam int RANDOM_ITEMS = 1200;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_PERCENT = 25;

	// how a generated frame fills its header and address fields
	typedef enum int {MAC_GOOD, MAC_FLIP, MAC_ANY} mac_pick_e;
	typedef enum int {TYPE_IP4, TYPE_IP6, TYPE_NEAR, TYPE_ANY} type_pick_e;
	typedef enum int {ADDR_TARGET, ADDR_LOCAL, ADDR_NEAR, ADDR_ANY} addr_pick_e;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	frcr_pkg::in_t                  in_data   = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	frcr_pkg::out_t                 out_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [frcr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                    cfg_data  = '0;

	// shadow registers and per-frame classifier state
	frcr_pkg::cfg_t model_cfg;
	logic [10:0]    frame_pos    = '0;
	logic           mac_match    = 1'b1;
	logic [15:0]    ekind_seen   = '0;
	logic           local_match  = 1'b1;
	logic           target_match = 1'b1;

	frcr_pkg::out_t due_results[$];
	frcr_pkg::in_t  pending_bytes[$];
	frcr_pkg::in_t  frame_buf[$];
	frcr_pkg::in_t  carry_bytes[$];

	int fail_count    = 0;
	bit no_idle       = 1'b0;
	bit in_sent       = 1'b0;
	int hold_requests = 0;
	int holds_started = 0;
	int hold_left     = 0;

	frame_redirect_classify_rewrite_top #(
		.MAX_FRAME_BYTES(FRAME_CAP)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// address byte idx, first byte in the most significant position
	function automatic logic [7:0] addr_octet(logic [63:0] hi, logic [63:0] lo, int idx,
			int len);
		logic [127:0] full;
		full = {hi, lo};
		if (len == frcr_pkg::ADDR4_LEN)
			return lo[8 * (3 - idx) +: 8];
		return full[8 * (15 - idx) +: 8];
	endfunction

	// expected output for one frame byte; advances the frame state
	function automatic frcr_pkg::out_t classify_byte(frcr_pkg::in_t item);
		frcr_pkg::out_t res;
		int             p;
		int             sh;
		int             a_start;
		int             a_len;
		logic [7:0]     b;
		b = item.frame_byte;
		p = int'(frame_pos);
		a_start = 0;
		a_len = 0;
		res.out_byte = b;
		res.frame_end = item.last_byte;
		res.redirect = 1'b0;

		// destination MAC is checked against local and replaced by spoof
		if (p < frcr_pkg::MAC_BYTES) begin
			sh = 8 * (frcr_pkg::MAC_BYTES - 1 - p);
			if (model_cfg.local_mac[sh +: 8] != b)
				mac_match = 1'b0;
			res.out_byte = model_cfg.spoof_mac[sh +: 8];
		end else if (p == frcr_pkg::ETYPE_HI_POS) begin
			ekind_seen[15:8] = b;
		end else if (p == frcr_pkg::ETYPE_LO_POS) begin
			ekind_seen[7:0] = b;
		end

		if (ekind_seen == frcr_pkg::ETYPE_IP4) begin
			a_start = frcr_pkg::IP4_ADDR_POS;
			a_len = frcr_pkg::ADDR4_LEN;
		end else if (ekind_seen == frcr_pkg::ETYPE_IP6) begin
			a_start = frcr_pkg::IP6_ADDR_POS;
			a_len = frcr_pkg::ADDR6_LEN;
		end

		// destination address window
		if (p > frcr_pkg::ETYPE_LO_POS && a_len != 0 && p >= a_start
				&& p < a_start + a_len) begin
			if (addr_octet(model_cfg.local_addr_high, model_cfg.local_addr_low,
					p - a_start, a_len) != b)
				local_match = 1'b0;
			if (addr_octet(model_cfg.target_addr_high, model_cfg.target_addr_low,
					p - a_start, a_len) != b)
				target_match = 1'b0;
		end

		// verdict on the last byte, then a fresh frame
		if (item.last_byte) begin
			if (mac_match && a_len != 0 && p >= a_start + a_len - 1
					&& model_cfg.addr_size == a_len)
				res.redirect = model_cfg.gateway_mode ? !local_match : target_match;
			frame_pos = '0;
			mac_match = 1'b1;
			ekind_seen = '0;
			local_match = 1'b1;
			target_match = 1'b1;
		end else if (frame_pos < FRAME_CAP - 1) begin
			frame_pos = frame_pos + 11'd1;
		end
		return res;
	endfunction

	function automatic logic [63:0] wide_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// input side: one byte per transfer, random gaps unless no_idle
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_sent)) begin
			if (pending_bytes.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
				in_data <= pending_bytes.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (holds_started != hold_requests) begin
			holds_started = holds_started + 1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && $urandom_range(99) < IDLE_PERCENT;
		end
	end

	// check output transfers, predict input transfers
	always @(posedge clk) begin : monitor
		frcr_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("output transfer with nothing outstanding: %h", out_data);
				fail_count++;
			end else begin
				want = due_results.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
					fail_count++;
				end
				if (out_data.frame_end !== want.frame_end) begin
					$error("frame_end: expected %b, actual %b", want.frame_end,
						out_data.frame_end);
					fail_count++;
				end
				if (out_data.redirect !== want.redirect) begin
					$error("redirect: expected %b, actual %b", want.redirect, out_data.redirect);
					fail_count++;
				end
			end
		end
		in_sent = arst_n && in_valid && !in_stall;
		if (in_sent)
			due_results.push_back(classify_byte(in_data));
	end

	task automatic write_reg(input logic [frcr_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			frcr_pkg::REG_LOCAL_MAC:   model_cfg.local_mac = val[47:0];
			frcr_pkg::REG_SPOOF_MAC:   model_cfg.spoof_mac = val[47:0];
			frcr_pkg::REG_LOCAL_HIGH:  model_cfg.local_addr_high = val;
			frcr_pkg::REG_LOCAL_LOW:   model_cfg.local_addr_low = val;
			frcr_pkg::REG_TARGET_HIGH: model_cfg.target_addr_high = val;
			frcr_pkg::REG_TARGET_LOW:  model_cfg.target_addr_low = val;
			frcr_pkg::REG_ADDR_SIZE:   model_cfg.addr_size = val[4:0];
			frcr_pkg::REG_GATEWAY:     model_cfg.gateway_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// block drained: no byte waiting, none in flight
	task automatic wait_idle();
		while (pending_bytes.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	// new register setting; the first phases walk both sizes and both modes
	task automatic reconfigure(input int phase);
		logic [63:0] v;
		int          size;
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_LOCAL_MAC, wide_value());
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_SPOOF_MAC, wide_value());
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_LOCAL_HIGH, wide_value());
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_LOCAL_LOW, wide_value());
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_TARGET_HIGH, wide_value());
		if (phase < 4 || $urandom_range(1) != 0)
			write_reg(frcr_pkg::REG_TARGET_LOW, wide_value());
		if (phase < 4) begin
			size = phase[0] ? frcr_pkg::ADDR6_LEN : frcr_pkg::ADDR4_LEN;
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3: size = frcr_pkg::ADDR4_LEN;
				4, 5, 6, 7: size = frcr_pkg::ADDR6_LEN;
				8:          size = $urandom_range(1) ? 31 : 0;
				default:    size = $urandom_range(31);
			endcase
		end
		v = {$urandom, $urandom};
		v[4:0] = 5'(size);
		write_reg(frcr_pkg::REG_ADDR_SIZE, v);
		v = {$urandom, $urandom};
		v[0] = (phase < 4) ? phase[1] : 1'($urandom_range(1));
		write_reg(frcr_pkg::REG_GATEWAY, v);
		// indexes past the register list are dropped
		if ($urandom_range(3) == 0)
			write_reg(frcr_pkg::REG_GATEWAY + 4'($urandom_range(1, 8)), wide_value());
		close_writes();
	endtask

	// one frame into frame_buf, using the current register values
	task automatic make_frame(input int len, input mac_pick_e mac_sel, input type_pick_e type_sel,
			input addr_pick_e addr_sel);
		logic [15:0]   etype;
		logic [7:0]    b;
		frcr_pkg::in_t item;
		int            a_start;
		int            a_len;
		int            flip_pos;
		int            flip_bit;
		frame_buf.delete();
		flip_pos = $urandom_range(15);
		flip_bit = $urandom_range(7);
		case (type_sel)
			TYPE_IP4:  etype = frcr_pkg::ETYPE_IP4;
			TYPE_IP6:  etype = frcr_pkg::ETYPE_IP6;
			TYPE_NEAR: etype = ($urandom_range(1) ? frcr_pkg::ETYPE_IP6 : frcr_pkg::ETYPE_IP4)
				^ (16'h0001 << $urandom_range(15));
			default:   etype = 16'($urandom);
		endcase
		a_start = 0;
		a_len = 0;
		if (etype == frcr_pkg::ETYPE_IP4) begin
			a_start = frcr_pkg::IP4_ADDR_POS;
			a_len = frcr_pkg::ADDR4_LEN;
		end else if (etype == frcr_pkg::ETYPE_IP6) begin
			a_start = frcr_pkg::IP6_ADDR_POS;
			a_len = frcr_pkg::ADDR6_LEN;
		end
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i < frcr_pkg::MAC_BYTES) begin
				if (mac_sel != MAC_ANY)
					b = model_cfg.local_mac[8 * (frcr_pkg::MAC_BYTES - 1 - i) +: 8];
				if (mac_sel == MAC_FLIP && i == flip_pos % frcr_pkg::MAC_BYTES)
					b = b ^ (8'h01 << flip_bit);
			end else if (i == frcr_pkg::ETYPE_HI_POS) begin
				b = etype[15:8];
			end else if (i == frcr_pkg::ETYPE_LO_POS) begin
				b = etype[7:0];
			end else if (a_len != 0 && i >= a_start && i < a_start + a_len) begin
				case (addr_sel)
					ADDR_TARGET, ADDR_NEAR: b = addr_octet(model_cfg.target_addr_high,
						model_cfg.target_addr_low, i - a_start, a_len);
					ADDR_LOCAL: b = addr_octet(model_cfg.local_addr_high,
						model_cfg.local_addr_low, i - a_start, a_len);
					default: ;
				endcase
				if (addr_sel == ADDR_NEAR && i - a_start == flip_pos % a_len)
					b = b ^ (8'h01 << flip_bit);
			end
			item.frame_byte = b;
			item.last_byte = (i == len - 1);
			frame_buf.push_back(item);
		end
	endtask

	// mostly well-formed frames ending near the address, some short, long or noisy
	task automatic random_frame();
		mac_pick_e  mac_sel;
		type_pick_e type_sel;
		addr_pick_e addr_sel;
		int         a_end;
		int         len;
		int         r;
		r = $urandom_range(99);
		mac_sel = (r < 80) ? MAC_GOOD : (r < 90) ? MAC_FLIP : MAC_ANY;
		r = $urandom_range(99);
		type_sel = (r < 45) ? TYPE_IP4 : (r < 85) ? TYPE_IP6 : (r < 93) ? TYPE_NEAR : TYPE_ANY;
		r = $urandom_range(99);
		addr_sel = (r < 40) ? ADDR_TARGET : (r < 70) ? ADDR_LOCAL : (r < 85) ? ADDR_NEAR : ADDR_ANY;
		a_end = (type_sel == TYPE_IP6) ? frcr_pkg::IP6_ADDR_END : frcr_pkg::IP4_ADDR_END;
		r = $urandom_range(99);
		if (r < 55)
			len = a_end + $urandom_range(8);
		else if (r < 70)
			len = a_end;
		else if (r < 85)
			len = $urandom_range(1, a_end - 1);
		else
			len = $urandom_range(a_end + 9, a_end + 60);
		make_frame(len, mac_sel, type_sel, addr_sel);
	endtask

	initial begin : stimulus
		frcr_pkg::in_t item;
		int            phase;
		int            random_items;
		int            quota;
		int            cut;
		model_cfg = '0;
		model_cfg.addr_size = 5'(frcr_pkg::ADDR4_LEN);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every register once, local MAC all ones, spoof MAC all zero
		write_reg(frcr_pkg::REG_LOCAL_MAC, '1);
		write_reg(frcr_pkg::REG_SPOOF_MAC, '0);
		write_reg(frcr_pkg::REG_LOCAL_HIGH, {$urandom, $urandom});
		write_reg(frcr_pkg::REG_LOCAL_LOW, {$urandom, $urandom});
		write_reg(frcr_pkg::REG_TARGET_HIGH, {$urandom, $urandom});
		write_reg(frcr_pkg::REG_TARGET_LOW, {$urandom, $urandom});
		write_reg(frcr_pkg::REG_ADDR_SIZE, 64'(frcr_pkg::ADDR4_LEN));
		write_reg(frcr_pkg::REG_GATEWAY, '0);
		write_reg(frcr_pkg::REG_GATEWAY + 4'd1, '1);
		close_writes();

		// one-byte frames at both byte extremes, then a frame cut after the EtherType
		item.frame_byte = 8'hFF;
		item.last_byte = 1'b1;
		pending_bytes.push_back(item);
		item.frame_byte = 8'h00;
		pending_bytes.push_back(item);
		make_frame(frcr_pkg::ETYPE_LO_POS + 1, MAC_GOOD, TYPE_IP4, ADDR_TARGET);
		foreach (frame_buf[i])
			pending_bytes.push_back(frame_buf[i]);
		wait_idle();

		// swapped MAC extremes, frame that stops right after the MAC
		write_reg(frcr_pkg::REG_LOCAL_MAC, '0);
		write_reg(frcr_pkg::REG_SPOOF_MAC, '1);
		close_writes();
		make_frame(frcr_pkg::MAC_BYTES, MAC_GOOD, TYPE_IP6, ADDR_TARGET);
		foreach (frame_buf[i])
			pending_bytes.push_back(frame_buf[i]);

		// random phases, registers rewritten in between
		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			reconfigure(phase);
			no_idle = (phase % 8 == 5);
			// rest of a frame left open across the register update
			while (carry_bytes.size() != 0)
				pending_bytes.push_back(carry_bytes.pop_front());
			quota = no_idle ? 200 : $urandom_range(50, 110);
			while (quota > 0) begin
				random_frame();
				quota -= frame_buf.size();
				random_items += frame_buf.size();
				foreach (frame_buf[i])
					pending_bytes.push_back(frame_buf[i]);
			end
			if ($urandom_range(2) == 0) begin
				random_frame();
				if (frame_buf.size() > 1) begin
					cut = $urandom_range(1, frame_buf.size() - 1);
					random_items += frame_buf.size();
					repeat (cut)
						pending_bytes.push_back(frame_buf.pop_front());
					carry_bytes = frame_buf;
				end
			end
			// output held off while the input keeps offering
			if (phase % 5 == 2)
				hold_requests++;
			phase++;
		end
		while (carry_bytes.size() != 0)
			pending_bytes.push_back(carry_bytes.pop_front());
		wait_idle();
		repeat (8) @(posedge clk);

		if (fail_count == 0 && due_results.size() == 0)
			$display("frame_redirect_classify_rewrite_top_test: PASS");
		else
			$display("frame_redirect_classify_rewrite_top_test: FAIL");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("frame_redirect_classify_rewrite_top_test: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/frcr_pkg.sv
src/frcr_cfg_regs.sv
src/frcr_engine.sv
src/frame_redirect_classify_rewrite_top.sv
tb/frame_redirect_classify_rewrite_top_test.sv
